/* hw/rtl/rsh_pkg.sv */
// Shared types and constants for the ray/sphere hit shader.
// Used by rsh_shade, the top level and the bench; no dependencies.
package rsh_pkg;

  localparam int WordWidth = 16;
  localparam int FracBits  = 12;

  // Shading constants: 255.99 scaled by 100, and reciprocals for /100 and /1000.
  localparam logic [14:0] ColorScale  = 15'd25599;
  localparam logic [14:0] RecipHundred = 15'd20972;   // ceil(2^21 / 100)
  localparam int          RecipHundredShift = 21;
  localparam logic [18:0] RecipThousand = 19'd268436; // ceil(2^28 / 1000)
  localparam int          RecipThousandShift = 28;

  typedef enum logic [1:0] {
    CfgCenterX = 2'd0,
    CfgCenterY = 2'd1,
    CfgCenterZ = 2'd2,
    CfgRadius  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WordWidth-1:0] origin_x;
    logic signed [WordWidth-1:0] origin_y;
    logic signed [WordWidth-1:0] origin_z;
    logic signed [WordWidth-1:0] direction_x;
    logic signed [WordWidth-1:0] direction_y;
    logic signed [WordWidth-1:0] direction_z;
  } ray_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       sphere_hit;
  } color_t;

endpackage

/* hw/rtl/rsh_delay.sv */
// Enabled shift line that aligns side data with the arithmetic stages.
// No package dependency.
module rsh_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign d_o = tap_q[DEPTH-1];

endmodule

/* hw/rtl/rsh_disc.sv */
// Six-stage discriminant unit: products, dot sums, magnitudes, split
// products, wide sums, sign compare. Also exposes D.D after stage two.
module rsh_disc #(
  parameter int W = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W:0]   oc_i [3],
  input  logic signed [W-1:0] dir_i [3],
  input  logic [W-2:0]        radius_i,
  output logic [2*W-1:0]      len2_o,
  output logic                hit_o
);

  localparam int AW = 2 * W;
  localparam int HW = 2 * W + 3;
  localparam int HM = HW - 1;
  localparam int CW = 2 * W + 3;
  localparam int CM = CW - 1;
  localparam int L  = W + 1;
  localparam int PW = 4 * W + 4;

  logic signed [2*W:0]   od_q [3];
  logic signed [2*W+1:0] oo_q [3];
  logic signed [2*W-1:0] dd_q [3];
  logic [2*W-3:0]        rr_q;

  logic [AW-1:0]         a_q;
  logic signed [HW-1:0]  h_q;
  logic signed [CW-1:0]  c_q;

  logic [AW-1:0]         a3_q;
  logic [HM-1:0]         hm_q;
  logic [CM-1:0]         cm_q;
  logic                  cneg3_q;

  logic [2*L-1:0]        phh_q, phl_q, pll_q;
  logic [2*W:0]          qhh_q, qhl_q, qlh_q, qll_q;
  logic                  cneg4_q;

  logic [PW-1:0]         p_q, q_q;
  logic                  cneg5_q;

  logic                  hit_q;

  logic signed [HW-1:0]  h_neg;
  logic signed [CW-1:0]  c_neg;

  assign h_neg = -h_q;
  assign c_neg = -c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        od_q[i] <= oc_i[i] * dir_i[i];
        oo_q[i] <= oc_i[i] * oc_i[i];
        dd_q[i] <= dir_i[i] * dir_i[i];
      end
      rr_q <= radius_i * radius_i;

      a_q <= AW'($unsigned(dd_q[0])) + AW'($unsigned(dd_q[1])) + AW'($unsigned(dd_q[2]));
      h_q <= HW'(od_q[0]) + HW'(od_q[1]) + HW'(od_q[2]);
      c_q <= CW'(oo_q[0]) + CW'(oo_q[1]) + CW'(oo_q[2]) - CW'(rr_q);

      a3_q    <= a_q;
      hm_q    <= h_q[HW-1] ? h_neg[HM-1:0] : h_q[HM-1:0];
      cm_q    <= c_q[CW-1] ? c_neg[CM-1:0] : c_q[CM-1:0];
      cneg3_q <= c_q[CW-1];

      phh_q   <= hm_q[HM-1:L] * hm_q[HM-1:L];
      phl_q   <= hm_q[HM-1:L] * hm_q[L-1:0];
      pll_q   <= hm_q[L-1:0] * hm_q[L-1:0];
      qhh_q   <= a3_q[AW-1:W] * cm_q[CM-1:L];
      qhl_q   <= a3_q[AW-1:W] * cm_q[L-1:0];
      qlh_q   <= a3_q[W-1:0] * cm_q[CM-1:L];
      qll_q   <= a3_q[W-1:0] * cm_q[L-1:0];
      cneg4_q <= cneg3_q;

      p_q <= (PW'(phh_q) << (2 * L)) + (PW'(phl_q) << (L + 1)) + PW'(pll_q);
      q_q <= (PW'(qhh_q) << (2 * W + 1)) + (PW'(qhl_q) << W)
           + (PW'(qlh_q) << (W + 1)) + PW'(qll_q);
      cneg5_q <= cneg4_q;

      hit_q <= cneg5_q ? ((p_q != '0) || (q_q != '0)) : (p_q > q_q);
    end
  end

  assign len2_o = a_q;
  assign hit_o  = hit_q;

endmodule

/* hw/rtl/rsh_isqrt.sv */
// Pipelined integer square root, one result bit per stage (W stages).
// Carries a side tag alongside the root. No package dependency.
module rsh_isqrt #(
  parameter int W  = 16,
  parameter int TW = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] val_i,
  input  logic [TW-1:0]  tag_i,
  output logic [W-1:0]   root_o,
  output logic [TW-1:0]  tag_o
);

  logic [2*W-1:0] v_s   [W];
  logic [2*W-1:0] r_s   [W];
  logic [TW-1:0]  tag_s [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam logic [2*W-1:0] Bit = {{(2*W-1){1'b0}}, 1'b1} << (2 * (W - 1 - k));
    logic [2*W-1:0] v_in, r_in, v_q, r_q;
    logic [TW-1:0]  tag_in, tag_q;
    logic [2*W:0]   trial;

    if (k == 0) begin : g_first
      assign v_in   = val_i;
      assign r_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_s[k-1];
      assign r_in   = r_s[k-1];
      assign tag_in = tag_s[k-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, Bit};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q <= tag_in;
        if ({1'b0, v_in} >= trial) begin
          v_q <= v_in - trial[2*W-1:0];
          r_q <= (r_in >> 1) + Bit;
        end else begin
          v_q <= v_in;
          r_q <= r_in >> 1;
        end
      end
    end

    assign v_s[k]   = v_q;
    assign r_s[k]   = r_q;
    assign tag_s[k] = tag_q;
  end

  assign root_o = r_s[W-1][W-1:0];
  assign tag_o  = tag_s[W-1];

endmodule

/* hw/rtl/rsh_div.sv */
// Pipelined restoring divide of |dy| by the length, F+1 quotient bits.
// Gives |uy| in Q.F, its sign, and a zero-length flag.
module rsh_div #(
  parameter int W = 16,
  parameter int F = 12
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] len_i,
  input  logic [W-1:0] mag_i,
  input  logic         neg_i,
  output logic [F:0]   uy_mag_o,
  output logic         neg_o,
  output logic         zero_o
);

  localparam int N = F + 1;

  logic [W:0]   rem_s  [N];
  logic [F:0]   quo_s  [N];
  logic [W-1:0] len_s  [N];
  logic         neg_s  [N];
  logic         zero_s [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W:0]   rem_in, rem_q, rem_sub;
    logic [F:0]   quo_in, quo_q;
    logic [W-1:0] len_in, len_q;
    logic         neg_in, neg_q, zero_in, zero_q, ge;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, mag_i};
      assign quo_in  = '0;
      assign len_in  = len_i;
      assign neg_in  = neg_i;
      assign zero_in = (len_i == '0);
    end else begin : g_next
      assign rem_in  = rem_s[k-1];
      assign quo_in  = quo_s[k-1];
      assign len_in  = len_s[k-1];
      assign neg_in  = neg_s[k-1];
      assign zero_in = zero_s[k-1];
    end

    assign ge      = (rem_in >= {1'b0, len_in});
    assign rem_sub = ge ? (rem_in - {1'b0, len_in}) : rem_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_sub << 1;
        quo_q  <= {quo_in[F-1:0], ge};
        len_q  <= len_in;
        neg_q  <= neg_in;
        zero_q <= zero_in;
      end
    end

    assign rem_s[k]  = rem_q;
    assign quo_s[k]  = quo_q;
    assign len_s[k]  = len_q;
    assign neg_s[k]  = neg_q;
    assign zero_s[k] = zero_q;
  end

  assign uy_mag_o = quo_s[N-1];
  assign neg_o    = neg_s[N-1];
  assign zero_o   = zero_s[N-1];

endmodule

/* hw/rtl/rsh_shade.sv */
// Three-stage sky blend and quantizer; selects red on a hit.
// Depends on rsh_pkg for scale and reciprocal constants and color_t.
module rsh_shade #(
  parameter int F = 12
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [F:0]      uy_mag_i,
  input  logic            neg_i,
  input  logic            zero_i,
  input  logic            hit_i,
  output rsh_pkg::color_t color_o
);
  import rsh_pkg::*;

  localparam logic [F+1:0] One  = {{1'b0, 1'b1}, {F{1'b0}}};
  localparam logic [F+1:0] Two  = {1'b1, {(F+1){1'b0}}};
  localparam logic [F+3:0] Ten  = (F+4)'(10) << F;

  logic [F+1:0]  mag_eff, t_sum, t_val, x1;
  logic [F+3:0]  x2;
  logic [F+16:0] n1_q;
  logic [F+18:0] n2_q;
  logic          hit_a_q, hit_b_q;
  logic [30:0]   p1_q;
  logic [37:0]   p2_q;
  color_t        color_q;

  assign mag_eff = zero_i ? '0 : {1'b0, uy_mag_i};
  assign t_sum   = neg_i ? (One - mag_eff) : (One + mag_eff);
  assign t_val   = t_sum >> 1;
  assign x1      = Two - t_val;
  assign x2      = Ten - ((F+4)'(t_val) + ((F+4)'(t_val) << 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q    <= (F+17)'(x1) * (F+17)'(ColorScale);
      n2_q    <= (F+19)'(x2) * (F+19)'(ColorScale);
      hit_a_q <= hit_i;

      p1_q    <= 31'(n1_q[F+16:F+1]) * 31'(RecipHundred);
      p2_q    <= 38'(n2_q[F+18:F]) * 38'(RecipThousand);
      hit_b_q <= hit_a_q;

      if (hit_b_q) begin
        color_q.red   <= 8'hFF;
        color_q.green <= 8'h00;
        color_q.blue  <= 8'h00;
      end else begin
        color_q.red   <= p1_q[RecipHundredShift+7:RecipHundredShift];
        color_q.green <= p2_q[RecipThousandShift+7:RecipThousandShift];
        color_q.blue  <= 8'hFF;
      end
      color_q.sphere_hit <= hit_b_q;
    end
  end

  assign color_o = color_q;

endmodule

/* hw/rtl/ray_sphere_hit_shader_unit.sv */
// Top level of the ray/sphere hit shader: config registers, input stage,
// valid line and stall control. Uses rsh_pkg, rsh_disc, rsh_isqrt, rsh_div,
// rsh_shade and rsh_delay.
//
//   port group  direction  beat
//   in_*        in         one ray (ray_t), valid/ready
//   out_*       out        one color (color_t), valid/ready
//   cfg_*       in         register write, index + data, no wait
//
// The path is one input stage, two discriminant stages to D.D feeding a
// WordWidth-stage square root, FRAC_BITS+1 divide stages and three shading
// stages; the hit flag from the six-stage discriminant is delayed to meet the
// shading stages. One beat per cycle while the output beat is not held.
// Reset clears the valid line and loads the default sphere.
// All stages hold together while the output beat waits; in_ready_o is low then.
module ray_sphere_hit_shader_unit #(
  parameter int FRAC_BITS = rsh_pkg::FracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rsh_pkg::ray_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rsh_pkg::color_t                  out_data_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [rsh_pkg::WordWidth-1:0]    cfg_data_i
);
  import rsh_pkg::*;

  localparam int W     = WordWidth;
  localparam int Depth = W + FRAC_BITS + 7;
  localparam int HitLag = W + FRAC_BITS - 3;
  localparam logic signed [W-1:0] CzReset = -(W'(1) << FRAC_BITS);
  localparam logic [W-2:0]        RReset  = (W-1)'(1) << (FRAC_BITS - 1);

  logic signed [W-1:0] cx_q, cy_q, cz_q;
  logic [W-2:0]        r_q;
  logic [Depth-1:0]    valid_q;
  logic                en;

  logic signed [W:0]   oc_q [3];
  logic signed [W-1:0] dir_q [3];
  logic [W:0]          dy_tag_q;
  logic [W-1:0]        dy_mag;
  logic signed [W-1:0] dy_neg;

  logic [2*W-1:0]      len2;
  logic                hit_early, hit_late;
  logic [W:0]          tag_d2, tag_root;
  logic [W-1:0]        root;
  logic [FRAC_BITS:0]  uy_mag;
  logic                uy_neg, len_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= CzReset;
      r_q  <= RReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgCenterX: cx_q <= cfg_data_i;
        CfgCenterY: cy_q <= cfg_data_i;
        CfgCenterZ: cz_q <= cfg_data_i;
        CfgRadius:  r_q  <= cfg_data_i[W-2:0];
        default:    ;
      endcase
    end
  end

  assign en         = !valid_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-2:0], in_valid_i};
    end
  end

  assign dy_neg = -in_data_i.direction_y;
  assign dy_mag = in_data_i.direction_y[W-1] ? dy_neg : in_data_i.direction_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q[0]  <= (W+1)'(in_data_i.origin_x) - (W+1)'(cx_q);
      oc_q[1]  <= (W+1)'(in_data_i.origin_y) - (W+1)'(cy_q);
      oc_q[2]  <= (W+1)'(in_data_i.origin_z) - (W+1)'(cz_q);
      dir_q[0] <= in_data_i.direction_x;
      dir_q[1] <= in_data_i.direction_y;
      dir_q[2] <= in_data_i.direction_z;
      dy_tag_q <= {in_data_i.direction_y[W-1], dy_mag};
    end
  end

  rsh_disc #(.W(W)) u_disc (
    .clk_i    (clk_i),
    .en_i     (en),
    .oc_i     (oc_q),
    .dir_i    (dir_q),
    .radius_i (r_q),
    .len2_o   (len2),
    .hit_o    (hit_early)
  );

  rsh_delay #(.WIDTH(W + 1), .DEPTH(2)) u_tag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dy_tag_q),
    .d_o   (tag_d2)
  );

  rsh_delay #(.WIDTH(1), .DEPTH(HitLag)) u_hit_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (hit_early),
    .d_o   (hit_late)
  );

  rsh_isqrt #(.W(W), .TW(W + 1)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (len2),
    .tag_i  (tag_d2),
    .root_o (root),
    .tag_o  (tag_root)
  );

  rsh_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .en_i     (en),
    .len_i    (root),
    .mag_i    (tag_root[W-1:0]),
    .neg_i    (tag_root[W]),
    .uy_mag_o (uy_mag),
    .neg_o    (uy_neg),
    .zero_o   (len_zero)
  );

  rsh_shade #(.F(FRAC_BITS)) u_shade (
    .clk_i    (clk_i),
    .en_i     (en),
    .uy_mag_i (uy_mag),
    .neg_i    (uy_neg),
    .zero_i   (len_zero),
    .hit_i    (hit_late),
    .color_o  (out_data_o)
  );

  assign out_valid_o = valid_q[Depth-1];

endmodule

/* bench/tb.sv */
// Self-checking bench for ray_sphere_hit_shader_unit: directed rays from a table,
// then random rays over several sphere setups, checked against an inline predictor.
// Depends on rsh_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
  import rsh_pkg::*;

  typedef struct {
    ray_t   ray;
    bit     known;
    color_t color;
  } ray_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  ray_t   in_data_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  color_t out_data_o;
  logic   cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CfgCenterX;
  logic [WordWidth-1:0] cfg_data_i = '0;

  logic signed [WordWidth-1:0] center_x = 16'sd0;
  logic signed [WordWidth-1:0] center_y = 16'sd0;
  logic signed [WordWidth-1:0] center_z = -16'sd4096;
  logic [WordWidth-2:0] radius = 15'd2048;

  color_t pending_colors[$];
  int     mismatches = 0;
  bit     calm = 1'b0;

  always #2 clk_i = ~clk_i;

  ray_sphere_hit_shader_unit dut (.*);

  function automatic longint root_floor(longint v);
    longint res;
    longint bit_w;
    res = 0;
    bit_w = 64'sd1 <<< 62;
    while (bit_w > v) bit_w = bit_w >>> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >>> 1) + bit_w;
      end else begin
        res = res >>> 1;
      end
      bit_w = bit_w >>> 2;
    end
    return res;
  endfunction

  function automatic color_t shade_ray(ray_t r);
    longint org[3], dir[3], ctr[3], oc;
    longint a_sum, h_sum, c_sum, len, uy_mag, uy, t;
    logic signed [127:0] aa, hh, cc, disc;
    color_t col;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.direction_x, r.direction_y, r.direction_z};
    ctr = '{center_x, center_y, center_z};
    a_sum = 0;
    h_sum = 0;
    c_sum = 0;
    for (int i = 0; i < 3; i++) begin
      oc = org[i] - ctr[i];
      a_sum += dir[i] * dir[i];
      h_sum += oc * dir[i];
      c_sum += oc * oc;
    end
    c_sum -= longint'(radius) * longint'(radius);
    aa = a_sum;
    hh = h_sum;
    cc = c_sum;
    disc = hh * hh - aa * cc;
    if (disc > 0) begin
      col = '{red: 8'd255, green: 8'd0, blue: 8'd0, sphere_hit: 1'b1};
      return col;
    end
    len = root_floor(a_sum);
    uy_mag = 0;
    if (len != 0) begin
      uy_mag = ((dir[1] < 0 ? -dir[1] : dir[1]) <<< FracBits) / len;
      if (uy_mag > (1 << FracBits)) uy_mag = 1 << FracBits;
    end
    uy = (dir[1] < 0) ? -uy_mag : uy_mag;
    t = (uy + (1 << FracBits)) >>> 1;
    col.red = 8'((64'd25599 * ((2 << FracBits) - t)) / (100 * (2 << FracBits)));
    col.green = 8'((64'd25599 * (10 * (1 << FracBits) - 3 * t)) / (1000 * (1 << FracBits)));
    col.blue = 8'd255;
    col.sphere_hit = 1'b0;
    return col;
  endfunction

  task automatic send_ray(ray_t r, bit known, color_t col);
    in_data_i <= r;
    in_valid_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) break;
    end
    pending_colors.push_back(known ? col : shade_ray(r));
    if (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                              logic [15:0] rad);
    logic [15:0] vals[4];
    vals = '{cx, cy, cz, rad};
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    center_x = cx;
    center_y = cy;
    center_z = cz;
    radius = rad[14:0];
  endtask

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(16384) - 8192);
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord()};
    if ($urandom_range(2) == 0) begin
      r.direction_x = center_x - r.origin_x + 16'($urandom_range(1024) - 512);
      r.direction_y = center_y - r.origin_y + 16'($urandom_range(1024) - 512);
      r.direction_z = center_z - r.origin_z + 16'($urandom_range(1024) - 512);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    color_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        want = pending_colors.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("color mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    ray_row_t rows[$];
    color_t none;
    none = '0;
    rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd4096}, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b1}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{8'd191, 8'd217, 8'd255, 1'b0}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd0}, 1'b1, '{8'd127, 8'd179, 8'd255, 1'b0}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd4096, 16'sd0}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
      '{'{16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, -16'sd4096}, 1'b1,
        '{8'd191, 8'd217, 8'd255, 1'b0}},
      '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, none},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, none},
      '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0, none},
      '{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0, none},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'sd0}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'h7FFF, 16'sd0}, 1'b0, none},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1}, 1'b0, none}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].color);
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_sphere(16'h0000, 16'h0000, 16'hF000, 16'h0800);
        1: write_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: write_sphere(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        3: write_sphere(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        default: write_sphere(16'($urandom_range(8192) - 4096), 16'($urandom_range(8192) - 4096),
                              16'($urandom_range(8192) - 4096), 16'($urandom_range(8192)));
      endcase
      for (int n = 0; n < 90; n++) begin
        calm = (phase == 4) && (n >= 20) && (n < 70);
        send_ray(random_ray(), 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* ray_sphere_hit_shader_unit.f */
hw/rtl/rsh_pkg.sv
hw/rtl/rsh_delay.sv
hw/rtl/rsh_disc.sv
hw/rtl/rsh_isqrt.sv
hw/rtl/rsh_div.sv
hw/rtl/rsh_shade.sv
hw/rtl/ray_sphere_hit_shader_unit.sv
bench/tb.sv
